// ===== hw/rtl/reciprocal_frequency_counter_defines.svh =====
// Assertion macros shared by the frequency counter modules.
`ifndef RECIPROCAL_FREQUENCY_COUNTER_DEFINES_SVH
`define RECIPROCAL_FREQUENCY_COUNTER_DEFINES_SVH

// Condition must never hold outside reset.
`define RFC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RFC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rfc_pkg.sv =====
// Shared constants, codes and types of the reciprocal frequency counter.
package rfc_pkg;

	localparam int TICK_WIDTH    = 32;
	localparam int FRACTION_BITS = 8;

	// Register field widths
	localparam int MODE_W    = 2;
	localparam int CLK_W     = 27;
	localparam int TIMEOUT_W = 32;
	localparam int EXTDIV_W  = 9;
	localparam int HZ_W      = 35;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = HZ_W;

	// Datapath widths
	localparam int SUM_W   = TICK_WIDTH + 3;
	localparam int CMP_W   = (TICK_WIDTH > TIMEOUT_W) ? TICK_WIDTH : TIMEOUT_W;
	localparam int NUM_W   = CLK_W + EXTDIV_W;
	localparam int DIV_W   = NUM_W + FRACTION_BITS;
	localparam int FREQ_W  = HZ_W + FRACTION_BITS;
	localparam int CMD_W   = 3;
	localparam int STATUS_W = 2;

	// Request queue between front and back
	localparam int REQ_DEPTH = 2;
	localparam int REQ_PTR_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
	localparam int REQ_CNT_W = $clog2(REQ_DEPTH + 1);

	// Commands
	localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_EDGE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_START = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOSIG = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_DIV   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_MAX   = 3'd7;

	typedef struct packed {
		logic [MODE_W-1:0]    smoothing_mode;
		logic [CLK_W-1:0]     clock_hz;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [EXTDIV_W-1:0]  extended_divisor;
		logic [HZ_W-1:0]      normal_min_hz;
		logic [HZ_W-1:0]      normal_max_hz;
		logic [HZ_W-1:0]      extended_min_hz;
		logic [HZ_W-1:0]      extended_max_hz;
	} cfg_t;

	// Read request as classified by the front part
	typedef struct packed {
		logic                  no_signal;
		logic                  ext;
		logic [TICK_WIDTH-1:0] period;
	} req_t;

endpackage

// ===== hw/rtl/reciprocal_frequency_counter.sv =====
// Reads: a read without signal skips the multiply and divide steps.
// Throughput: ticks, edges, start and stop are taken one per cycle while full is low;
// each read ties up the shared one-bit-per-cycle divider, and full rises while
// two reads wait in the request queue.
// Reset: arst_n clears all timebase state asynchronously (stopped, block length four)
// and loads every configuration register with its reset value.
module reciprocal_frequency_counter import rfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [CMD_W-1:0]      command,
	input  logic                  extended_range,
	output logic                  empty,
	input  logic                  pop,
	output logic [STATUS_W-1:0]   status,
	output logic [FREQ_W-1:0]     frequency_q8,
	output logic                  range_used,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic take;
	logic req_push;
	req_t req_in;
	logic req_full;
	logic req_pop;
	req_t req_out;
	logic req_empty;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;
	assign full      = req_full;

	// Write configuration registers on a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_mode   <= MODE_W'(1);
			cfg_q.clock_hz         <= CLK_W'(16000000);
			cfg_q.timeout_ticks    <= TIMEOUT_W'(16000000);
			cfg_q.extended_divisor <= EXTDIV_W'(1);
			cfg_q.normal_min_hz    <= HZ_W'(1);
			cfg_q.normal_max_hz    <= HZ_W'(8000000);
			cfg_q.extended_min_hz  <= HZ_W'(1);
			cfg_q.extended_max_hz  <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SMOOTHING: cfg_q.smoothing_mode   <= cfg_data[MODE_W-1:0];
				REG_CLOCK_HZ:  cfg_q.clock_hz         <= cfg_data[CLK_W-1:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks    <= cfg_data[TIMEOUT_W-1:0];
				REG_EXT_DIV:   cfg_q.extended_divisor <= cfg_data[EXTDIV_W-1:0];
				REG_NORM_MIN:  cfg_q.normal_min_hz    <= cfg_data[HZ_W-1:0];
				REG_NORM_MAX:  cfg_q.normal_max_hz    <= cfg_data[HZ_W-1:0];
				REG_EXT_MIN:   cfg_q.extended_min_hz  <= cfg_data[HZ_W-1:0];
				REG_EXT_MAX:   cfg_q.extended_max_hz  <= cfg_data[HZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rfc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.take           (take),
		.command        (command),
		.extended_range (extended_range),
		.req_push       (req_push),
		.req            (req_in)
	);

	rfc_req_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_push),
		.din    (req_in),
		.full   (req_full),
		.pop    (req_pop),
		.dout   (req_out),
		.empty  (req_empty)
	);

	rfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.req_empty    (req_empty),
		.req          (req_out),
		.req_pop      (req_pop),
		.pop          (pop),
		.empty        (empty),
		.status       (status),
		.frequency_q8 (frequency_q8),
		.range_used   (range_used)
	);

endmodule

// ===== hw/rtl/rfc_req_queue.sv =====
// Short register queue carrying read requests from front to back.
module rfc_req_queue import rfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t din,
	output logic full,
	input  logic pop,
	output req_t dout,
	output logic empty
);

	`include "reciprocal_frequency_counter_defines.svh"

	req_t                 entries_q [REQ_DEPTH];
	logic [REQ_PTR_W-1:0] wptr_q;
	logic [REQ_PTR_W-1:0] rptr_q;
	logic [REQ_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == REQ_CNT_W'(REQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entries_q[rptr_q];

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wptr_q] <= din;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : wptr_q + REQ_PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == REQ_PTR_W'(REQ_DEPTH - 1)) ? '0 : rptr_q + REQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + REQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - REQ_CNT_W'(1);
			end
		end
	end

	`RFC_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "request pushed into full queue")

endmodule

// ===== hw/rtl/rfc_front.sv =====
// Front part: timestamps edges, averages periods and classifies read requests.
module rfc_front import rfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             take,
	input  logic [CMD_W-1:0] command,
	input  logic             extended_range,
	output logic             req_push,
	output req_t             req
);

	logic [TICK_WIDTH-1:0] tick_q;
	logic [TICK_WIDTH-1:0] last_edge_q;
	logic [TICK_WIDTH-1:0] avg_period_q;
	logic [1:0]            edge_cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [3:0]            pib_q;
	logic [3:0]            blk_len_q;
	logic                  running_q;

	logic [TICK_WIDTH-1:0] period;
	logic [TICK_WIDTH-1:0] elapsed;
	logic [SUM_W-1:0]      sum_next;
	logic [3:0]            pib_next;
	logic                  blk_done;
	logic [1:0]            avg_shift;
	logic [TICK_WIDTH-1:0] avg_next;
	logic                  timed_out;

	// Block length for a smoothing mode; mode three falls back to four
	function automatic logic [3:0] mode_len(logic [MODE_W-1:0] mode);
		logic [3:0] len;
		case (mode)
			2'd0:    len = 4'd1;
			2'd2:    len = 4'd8;
			default: len = 4'd4;
		endcase
		return len;
	endfunction

	// Shift that divides by a block length of one, four or eight
	function automatic logic [1:0] len_shift(logic [3:0] len);
		logic [1:0] sh;
		case (len)
			4'd1:    sh = 2'd0;
			4'd8:    sh = 2'd3;
			default: sh = 2'd2;
		endcase
		return sh;
	endfunction

	// Period and block mean for an edge on this tick
	always_comb begin
		period   = tick_q - last_edge_q;
		sum_next = sum_q + SUM_W'(period);
		pib_next = pib_q + 4'd1;
		blk_done = (pib_next >= blk_len_q) || (avg_period_q == '0);
		// an empty average closes a block of one period
		avg_shift = (pib_next >= blk_len_q) ? len_shift(blk_len_q) : 2'd0;
		avg_next  = TICK_WIDTH'(sum_next >> avg_shift);
	end

	// Classify a read request
	always_comb begin
		elapsed       = tick_q - last_edge_q;
		timed_out     = CMP_W'(elapsed) > CMP_W'(cfg.timeout_ticks);
		req_push      = take && (command == CMD_READ);
		req.ext       = extended_range;
		req.period    = avg_period_q;
		req.no_signal = !running_q || (edge_cnt_q == 2'd0) || timed_out
			|| (edge_cnt_q == 2'd1) || (avg_period_q == '0);
	end

	// Advance the timebase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			last_edge_q  <= '0;
			avg_period_q <= '0;
			edge_cnt_q   <= '0;
			sum_q        <= '0;
			pib_q        <= '0;
			blk_len_q    <= 4'd4;
			running_q    <= 1'b0;
		end else if (take) begin
			unique case (command) inside
				CMD_TICK, CMD_EDGE: begin
					if (running_q) begin
						if (command == CMD_EDGE) begin
							if (edge_cnt_q != 2'd0) begin
								if (blk_done) begin
									avg_period_q <= avg_next;
									sum_q        <= '0;
									pib_q        <= '0;
								end else begin
									sum_q <= sum_next;
									pib_q <= pib_next;
								end
							end
							last_edge_q <= tick_q;
							if (edge_cnt_q != 2'd2) begin
								edge_cnt_q <= edge_cnt_q + 2'd1;
							end
						end
						tick_q <= tick_q + TICK_WIDTH'(1);
					end
				end
				CMD_START: begin
					tick_q       <= '0;
					last_edge_q  <= '0;
					avg_period_q <= '0;
					edge_cnt_q   <= '0;
					sum_q        <= '0;
					pib_q        <= '0;
					blk_len_q    <= mode_len(cfg.smoothing_mode);
					running_q    <= 1'b1;
				end
				CMD_STOP: begin
					running_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rfc_back.sv =====
// Back part: divides clock, times the prescaler in extended range, by period, range checks and holds the result.
module rfc_back import rfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                req_empty,
	input  req_t                req,
	output logic                req_pop,
	input  logic                pop,
	output logic                empty,
	output logic [STATUS_W-1:0] status,
	output logic [FREQ_W-1:0]   frequency_q8,
	output logic                range_used
);

	`include "reciprocal_frequency_counter_defines.svh"

	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
	localparam logic [DIV_W-1:0] FRAC_MASK = (DIV_W'(1) << FRACTION_BITS) - DIV_W'(1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  ns_q;
	logic                  ext_q;
	logic [TICK_WIDTH-1:0] per_q;
	logic [TICK_WIDTH-1:0] rem_q;
	logic [DIV_W-1:0]      quo_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [FREQ_W-1:0]     freq_q;
	logic                  range_q;

	logic [EXTDIV_W-1:0]   factor;
	logic [NUM_W-1:0]      num;
	logic [TICK_WIDTH:0]   rem_shift;
	logic                  rem_ge;
	logic [TICK_WIDTH:0]   rem_diff;
	logic [NUM_W-1:0]      q0;
	logic                  r0_nz;
	logic [HZ_W-1:0]       lo;
	logic [HZ_W-1:0]       hi;
	logic                  sat;
	logic [STATUS_W-1:0]   fin_status;
	logic [FREQ_W-1:0]     fin_freq;
	logic                  slot_free;

	assign req_pop      = (state_q == ST_IDLE) && !req_empty;
	assign slot_free    = !out_valid_q || pop;
	assign empty        = !out_valid_q;
	assign status       = status_q;
	assign frequency_q8 = freq_q;
	assign range_used   = range_q;

	// Numerator: clock times prescaler in extended range
	always_comb begin
		factor = ext_q ? cfg.extended_divisor : EXTDIV_W'(1);
		num    = NUM_W'(cfg.clock_hz) * NUM_W'(factor);
	end

	// One restoring division step
	always_comb begin
		rem_shift = {rem_q, quo_q[DIV_W-1]};
		rem_ge    = rem_shift >= {1'b0, per_q};
		rem_diff  = rem_shift - {1'b0, per_q};
	end

	// Range check and saturation of the finished quotient
	always_comb begin
		q0    = quo_q[DIV_W-1:FRACTION_BITS];
		r0_nz = ((quo_q & FRAC_MASK) != '0) || (rem_q != '0);
		lo    = ext_q ? cfg.extended_min_hz : cfg.normal_min_hz;
		hi    = ext_q ? cfg.extended_max_hz : cfg.normal_max_hz;
		sat   = (quo_q >> FREQ_W) != '0;
		if (ns_q) begin
			fin_status = STATUS_NOSIG;
		end else if (q0 < NUM_W'(lo)) begin
			fin_status = STATUS_BELOW;
		end else if ((q0 > NUM_W'(hi)) || ((q0 == NUM_W'(hi)) && r0_nz)) begin
			fin_status = STATUS_ABOVE;
		end else begin
			fin_status = STATUS_VALID;
		end
		if (ns_q) begin
			fin_freq = '0;
		end else if (sat) begin
			fin_freq = '1;
		end else begin
			fin_freq = quo_q[FREQ_W-1:0];
		end
	end

	// Sequence one request through multiply, divide and finish; a no-signal request goes straight to finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!req_empty) begin
						state_q <= req.no_signal ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the divider
	always_ff @(posedge clk) begin
		if (req_pop) begin
			ns_q  <= req.no_signal;
			ext_q <= req.ext;
			per_q <= req.period;
		end
		if (state_q == ST_MUL) begin
			quo_q <= {num, {FRACTION_BITS{1'b0}}};
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[DIV_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[TICK_WIDTH-1:0] : rem_shift[TICK_WIDTH-1:0];
		end
	end

	// Hold the result until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && slot_free) begin
			status_q <= fin_status;
			freq_q   <= fin_freq;
			range_q  <= ext_q;
		end
	end

	`RFC_ASSERT_NEXT(a_div_runs, clk, arst_n, (state_q == ST_DIV) && (cnt_q != DIV_LAST), state_q == ST_DIV, "divider left early")
	`RFC_ASSERT_IMPL(a_rem_below, clk, arst_n, state_q == ST_DIV, rem_q < per_q, "remainder not below divisor")
	`RFC_ASSERT_NEXT(a_fin_out, clk, arst_n, (state_q == ST_FIN) && !out_valid_q, out_valid_q, "finished result not held")

endmodule
